>>> src/bkvt_pkg.sv
// Shared types, command and status codes for the bounded key value table.
package bkvt_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_ABSENT  = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic               vld;
    logic [1:0]         cmd;
    logic               refused;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic               hit;
    logic signed [31:0] hit_value;
    logic               free_seen;
  } tok_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } wr_t;

endpackage

>>> src/bkvt_cell.sv
// One table entry of the chain: matches the passing beat and forwards it to the next cell.
module bkvt_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bkvt_pkg::tok_t       tok_in,
  input  logic [IDX_W-1:0]     free_idx_in,
  input  bkvt_pkg::wr_t        wr,
  input  logic [IDX_W-1:0]     wr_idx,
  output bkvt_pkg::tok_t       tok_out,
  output logic [IDX_W-1:0]     free_idx_out,
  output logic                 occupied
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [31:0] entry_key;
  logic signed [31:0] entry_value;
  logic               match;
  bkvt_pkg::tok_t     tok_next;
  logic [IDX_W-1:0]   free_idx_next;

  assign match = occupied && (entry_key == tok_in.key);

  always_comb begin
    tok_next      = tok_in;
    free_idx_next = free_idx_in;
    if (tok_in.vld && !tok_in.refused) begin
      if (match && (tok_in.cmd inside {bkvt_pkg::CMD_ADD, bkvt_pkg::CMD_SEARCH,
                                       bkvt_pkg::CMD_REMOVE})) begin
        tok_next.hit       = 1'b1;
        tok_next.hit_value = entry_value;
      end
      if (!occupied && !tok_in.free_seen) begin
        tok_next.free_seen = 1'b1;
        free_idx_next      = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied    <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
      if (wr.en && wr_idx == MY_IDX) begin
        occupied <= 1'b1;
      end else if (tok_in.vld && !tok_in.refused && match &&
                   tok_in.cmd == bkvt_pkg::CMD_REMOVE) begin
        occupied <= 1'b0;
      end
    end
    tok_out.cmd       <= tok_next.cmd;
    tok_out.refused   <= tok_next.refused;
    tok_out.key       <= tok_next.key;
    tok_out.value     <= tok_next.value;
    tok_out.hit       <= tok_next.hit;
    tok_out.hit_value <= tok_next.hit_value;
    tok_out.free_seen <= tok_next.free_seen;
    free_idx_out      <= free_idx_next;
    if (wr.en && wr_idx == MY_IDX) begin
      entry_key   <= wr.key;
      entry_value <= wr.value;
    end else if (tok_in.vld && !tok_in.refused && match &&
                 tok_in.cmd == bkvt_pkg::CMD_ADD) begin
      entry_value <= tok_in.value;
    end
  end

endmodule

>>> src/bounded_key_value_table.sv
// Top level of the bounded key value table: a chain of entry cells and the result stage.
// An accepted command enters a head register and travels through one cell per cycle; done
// is registered from the output of the last cell.
// Busy stays high from the accepting edge until the result cycle; the result is shown
// for one cycle and the receiver cannot stall it.
// Synchronous reset empties the table at once and sets the limit to sixteen.
module bounded_key_value_table #(
  parameter int CAPACITY = bkvt_pkg::CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] old_value,
  output logic [4:0]         entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

  bkvt_pkg::tok_t   tok [0:CAPACITY];
  logic [IDX_W-1:0] fidx [0:CAPACITY];
  logic [CAPACITY-1:0] occupied;

  bkvt_pkg::tok_t   tok_head;
  logic [IDX_W-1:0] fidx_head;
  logic [4:0]       capacity_limit;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    lim_w;
  logic [CW-1:0]    eff_limit;
  logic             accept;
  logic [1:0]       status_next;
  logic signed [31:0] old_next;
  bkvt_pkg::wr_t    wr;
  bkvt_pkg::wr_t    wr_next;
  logic [IDX_W-1:0] wr_idx;
  bkvt_pkg::tok_t   last;

  assign accept    = start && !busy;
  assign lim_w     = CW'(capacity_limit);
  assign eff_limit = (lim_w > CW'(CAPACITY)) ? CW'(CAPACITY) : lim_w;
  assign last      = tok[CAPACITY];
  assign tok[0]    = tok_head;
  assign fidx[0]   = fidx_head;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      bkvt_cell #(
        .IDX_W(IDX_W),
        .IDX  (g)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .tok_in      (tok[g]),
        .free_idx_in (fidx[g]),
        .wr          (wr),
        .wr_idx      (wr_idx),
        .tok_out     (tok[g+1]),
        .free_idx_out(fidx[g+1]),
        .occupied    (occupied[g])
      );
    end
  endgenerate

  always_comb begin
    count_next    = count;
    status_next   = bkvt_pkg::ST_ABSENT;
    old_next      = '0;
    wr_next.en    = 1'b0;
    wr_next.key   = last.key;
    wr_next.value = last.value;
    if (last.refused) begin
      status_next = bkvt_pkg::ST_FULL;
    end else if (last.hit) begin
      status_next = bkvt_pkg::ST_PRESENT;
      old_next    = last.hit_value;
      if (last.cmd == bkvt_pkg::CMD_REMOVE && count != '0) begin
        count_next = count - CW'(1);
      end
    end else if (last.cmd == bkvt_pkg::CMD_ADD) begin
      if (last.free_seen) begin
        wr_next.en = 1'b1;
        count_next = count + CW'(1);
      end else begin
        status_next = bkvt_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      done           <= 1'b0;
      count          <= '0;
      capacity_limit <= bkvt_pkg::LIMIT_RESET;
      tok_head.vld   <= 1'b0;
      wr.en          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
      tok_head.vld <= accept;
      wr.en        <= last.vld && wr_next.en;
      done         <= last.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (last.vld) begin
        busy <= 1'b0;
      end
      if (last.vld) begin
        count <= count_next;
      end
    end
    if (accept) begin
      tok_head.cmd       <= cmd;
      tok_head.refused   <= (cmd == bkvt_pkg::CMD_ADD) && (count >= eff_limit);
      tok_head.key       <= key;
      tok_head.value     <= value;
      tok_head.hit       <= 1'b0;
      tok_head.hit_value <= '0;
      tok_head.free_seen <= 1'b0;
      fidx_head          <= '0;
    end
    if (last.vld) begin
      status      <= status_next;
      old_value   <= old_next;
      entry_count <= count_next[4:0];
      wr.key      <= wr_next.key;
      wr.value    <= wr_next.value;
      wr_idx      <= fidx[CAPACITY];
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == bkvt_pkg::ST_FULL) |-> (old_value == '0))
    else $error("refused add returned a nonzero old value");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (!busy && !done) |-> ($countones(occupied) == int'(count)))
    else $error("entry count disagrees with occupied cells");

endmodule
